>>> design/utf8_stream_validator_macros.svh
// Assertion macros shared by the validator's RTL.
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define UTF8SV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8_stream_validator: assertion failed");

// The consequent is checked in the cycle after the antecedent.
`define UTF8SV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8_stream_validator: assertion failed");

`endif

>>> design/u8sv_pkg.sv
package u8sv_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LEAD   = 3'd1,
    ST_TRUNCATED  = 3'd2,
    ST_BAD_CONT   = 3'd3,
    ST_BAD_SCALAR = 3'd4
  } status_t;

  localparam int unsigned CodeWidth = 21;

  typedef logic [CodeWidth-1:0] code_t;

  localparam logic [7:0] AsciiMax  = 8'h7F;
  localparam logic [7:0] Lead2Min  = 8'hC2;
  localparam logic [7:0] Lead2Max  = 8'hDF;
  localparam logic [7:0] Lead3Min  = 8'hE0;
  localparam logic [7:0] Lead3Max  = 8'hEF;
  localparam logic [7:0] Lead4Min  = 8'hF0;
  localparam logic [7:0] Lead4Max  = 8'hF4;
  localparam logic [1:0] ContTag   = 2'b10;

  localparam code_t Min2Byte      = 21'h000080;
  localparam code_t Min3Byte      = 21'h000800;
  localparam code_t Min4Byte      = 21'h010000;
  localparam code_t ScalarMax     = 21'h10FFFF;
  localparam code_t SurrogateLow  = 21'h00D800;
  localparam code_t SurrogateHigh = 21'h00DFFF;

  localparam logic [1:0] ClassOne   = 2'd0;
  localparam logic [1:0] ClassTwo   = 2'd1;
  localparam logic [1:0] ClassThree = 2'd2;
  localparam logic [1:0] ClassFour  = 2'd3;

endpackage

>>> design/utf8_stream_validator.sv
// An accepted byte waits in the input register and moves into the result register
// when the output side is not stalled; res_stall can hold it in the input register.
// Throughput: one byte per cycle while no stall holds the flow; the per-byte decode
// sits between the input register and the result register, and the sequence state updates as each byte advances.
// Reset (rst, synchronous, active high) empties both registers and clears the
// sequence and error state; the same state is cleared after every final byte.
`include "utf8_stream_validator_macros.svh"

module utf8_stream_validator
  import u8sv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       scalar_ends,
  output logic       verdict_ready,
  output logic [2:0] status
);

  logic       q_valid;
  logic [7:0] q_byte;
  logic       q_last;
  logic       advance;

  logic [1:0] bytes_owed;
  logic [1:0] bytes_owed_next;
  code_t      code_accum;
  code_t      code_accum_next;
  logic [1:0] seq_length_class;
  logic [1:0] seq_length_class_next;
  status_t    error_kind;
  status_t    error_kind_next;
  logic [1:0] error_bytes_owed;
  logic [1:0] error_bytes_owed_next;

  logic       ends_calc;
  status_t    status_calc;
  code_t      shifted;
  code_t      minimum;
  logic       pending;

  assign advance   = q_valid && (!res_valid || !res_stall);
  assign src_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!src_stall) begin
      q_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      q_byte <= data_byte;
      q_last <= end_of_text;
    end
  end

  assign shifted = {code_accum[CodeWidth-7:0], q_byte[5:0]};

  always_comb begin
    case (seq_length_class)
      ClassTwo:   minimum = Min2Byte;
      ClassThree: minimum = Min3Byte;
      ClassFour:  minimum = Min4Byte;
      default:    minimum = '0;
    endcase
  end

  always_comb begin
    bytes_owed_next       = bytes_owed;
    code_accum_next       = code_accum;
    seq_length_class_next = seq_length_class;
    error_kind_next       = error_kind;
    error_bytes_owed_next = error_bytes_owed;
    ends_calc             = 1'b0;

    if (error_kind != ST_OK) begin
      if (error_bytes_owed != 2'd0) begin
        error_bytes_owed_next = error_bytes_owed - 2'd1;
      end
    end else if (bytes_owed == 2'd0) begin
      if (q_byte <= AsciiMax) begin
        ends_calc = 1'b1;
      end else if (q_byte >= Lead2Min && q_byte <= Lead2Max) begin
        bytes_owed_next       = 2'd1;
        seq_length_class_next = ClassTwo;
        code_accum_next       = {{(CodeWidth-5){1'b0}}, q_byte[4:0]};
      end else if (q_byte >= Lead3Min && q_byte <= Lead3Max) begin
        bytes_owed_next       = 2'd2;
        seq_length_class_next = ClassThree;
        code_accum_next       = {{(CodeWidth-4){1'b0}}, q_byte[3:0]};
      end else if (q_byte >= Lead4Min && q_byte <= Lead4Max) begin
        bytes_owed_next       = 2'd3;
        seq_length_class_next = ClassFour;
        code_accum_next       = {{(CodeWidth-3){1'b0}}, q_byte[2:0]};
      end else begin
        error_kind_next       = ST_BAD_LEAD;
        error_bytes_owed_next = 2'd0;
      end
    end else if (q_byte[7:6] != ContTag) begin
      error_kind_next       = ST_BAD_CONT;
      error_bytes_owed_next = bytes_owed - 2'd1;
      bytes_owed_next       = 2'd0;
    end else begin
      code_accum_next = shifted;
      bytes_owed_next = bytes_owed - 2'd1;
      if (bytes_owed == 2'd1) begin
        if (shifted >= minimum && shifted <= ScalarMax &&
            !(shifted >= SurrogateLow && shifted <= SurrogateHigh)) begin
          ends_calc = 1'b1;
        end else begin
          error_kind_next       = ST_BAD_SCALAR;
          error_bytes_owed_next = 2'd0;
        end
        seq_length_class_next = ClassOne;
        code_accum_next       = '0;
      end
    end
  end

  always_comb begin
    pending = (error_kind_next == ST_OK) ? (bytes_owed_next != 2'd0)
                                         : (error_bytes_owed_next != 2'd0);
    if (!q_last) begin
      status_calc = ST_OK;
    end else if (pending) begin
      status_calc = ST_TRUNCATED;
    end else begin
      status_calc = error_kind_next;
    end
  end

  // The final byte of a text returns all sequence state to its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_owed       <= 2'd0;
      code_accum       <= '0;
      seq_length_class <= ClassOne;
      error_kind       <= ST_OK;
      error_bytes_owed <= 2'd0;
    end else if (advance) begin
      if (q_last) begin
        bytes_owed       <= 2'd0;
        code_accum       <= '0;
        seq_length_class <= ClassOne;
        error_kind       <= ST_OK;
        error_bytes_owed <= 2'd0;
      end else begin
        bytes_owed       <= bytes_owed_next;
        code_accum       <= code_accum_next;
        seq_length_class <= seq_length_class_next;
        error_kind       <= error_kind_next;
        error_bytes_owed <= error_bytes_owed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      scalar_ends   <= ends_calc;
      verdict_ready <= q_last;
      status        <= status_calc;
    end
  end

  `UTF8SV_ASSERT_SAME(a_status_only_on_verdict, res_valid && status != ST_OK, verdict_ready)
  `UTF8SV_ASSERT_NEXT(a_clear_after_final, advance && q_last,
                      bytes_owed == 2'd0 && error_kind == ST_OK && error_bytes_owed == 2'd0)
  `UTF8SV_ASSERT_SAME(a_no_owed_after_error, error_kind != ST_OK, bytes_owed == 2'd0)
  `UTF8SV_ASSERT_SAME(a_stall_only_when_full, src_stall, q_valid && res_valid && res_stall)

endmodule

>>> dv/tb_utf8_stream_validator.sv
`timescale 1ns / 1ps

module tb_utf8_stream_validator
  import u8sv_pkg::*;
();

  typedef struct packed {
    logic    ends;
    logic    ready;
    status_t st;
  } verdict_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       given;
    verdict_t   v;
  } stim_row_t;

  localparam int       WatchdogLimit = 1000;
  localparam int       DirectedRows  = 25;
  localparam verdict_t NoVerdict     = '{1'b0, 1'b0, ST_OK};

  // Rows with given set carry their expected result; the rest use the predictor.
  localparam stim_row_t Directed [DirectedRows] = '{
    '{8'h00, 1'b1, 1'b1, '{1'b1, 1'b1, ST_OK}},
    '{8'h7F, 1'b1, 1'b1, '{1'b1, 1'b1, ST_OK}},
    '{8'hFF, 1'b1, 1'b1, '{1'b0, 1'b1, ST_BAD_LEAD}},
    '{8'h80, 1'b1, 1'b1, '{1'b0, 1'b1, ST_BAD_LEAD}},
    '{8'hC1, 1'b1, 1'b1, '{1'b0, 1'b1, ST_BAD_LEAD}},
    '{8'hC2, 1'b0, 1'b0, NoVerdict},
    '{8'h80, 1'b1, 1'b0, NoVerdict},
    '{8'hE0, 1'b0, 1'b0, NoVerdict},
    '{8'h80, 1'b0, 1'b0, NoVerdict},
    '{8'h80, 1'b1, 1'b0, NoVerdict},
    '{8'hED, 1'b0, 1'b0, NoVerdict},
    '{8'hA0, 1'b0, 1'b0, NoVerdict},
    '{8'h80, 1'b1, 1'b0, NoVerdict},
    '{8'hF4, 1'b0, 1'b0, NoVerdict},
    '{8'h90, 1'b0, 1'b0, NoVerdict},
    '{8'h80, 1'b0, 1'b0, NoVerdict},
    '{8'h80, 1'b1, 1'b0, NoVerdict},
    '{8'hE2, 1'b0, 1'b0, NoVerdict},
    '{8'h41, 1'b1, 1'b0, NoVerdict},
    '{8'hE2, 1'b0, 1'b0, NoVerdict},
    '{8'h41, 1'b0, 1'b0, NoVerdict},
    '{8'h42, 1'b1, 1'b0, NoVerdict},
    '{8'hF4, 1'b1, 1'b1, '{1'b0, 1'b1, ST_TRUNCATED}},
    '{8'hF5, 1'b0, 1'b1, '{1'b0, 1'b0, ST_OK}},
    '{8'h41, 1'b1, 1'b1, '{1'b0, 1'b1, ST_BAD_LEAD}}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       src_valid = 1'b0;
  logic       src_stall;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic       scalar_ends;
  logic       verdict_ready;
  logic [2:0] status;

  logic [1:0] owed = '0;
  code_t      accum = '0;
  logic [1:0] len_class = ClassOne;
  status_t    err = ST_OK;
  logic [1:0] err_owed = '0;

  verdict_t   verdict_q [$];
  verdict_t   want;
  logic [7:0] text_bytes [$];
  int         errors = 0;
  int         accepted_in = 0;
  int         random_bytes = 0;
  int         idle_cycles = 0;
  bit         quiet = 1'b0;
  bit         calm = 1'b0;
  bit         paused = 1'b0;
  bit         rx_holding = 1'b0;
  bit         long_hold_done = 1'b0;

  wire in_fire  = src_valid && !src_stall;
  wire out_fire = !rst && res_valid && !res_stall;

  utf8_stream_validator u_top (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .data_byte    (data_byte),
    .end_of_text  (end_of_text),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .scalar_ends  (scalar_ends),
    .verdict_ready(verdict_ready),
    .status       (status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic verdict_t decode_byte(input logic [7:0] b, input logic last);
    verdict_t r;
    logic     still_owed;
    code_t    minimum;
    r = NoVerdict;
    r.ready = last;
    if (err != ST_OK) begin
      if (err_owed != 2'd0) err_owed = err_owed - 2'd1;
    end else if (owed == 2'd0) begin
      if (b <= AsciiMax) begin
        r.ends = 1'b1;
      end else if (b >= Lead2Min && b <= Lead2Max) begin
        owed = 2'd1;
        len_class = ClassTwo;
        accum = code_t'(b[4:0]);
      end else if (b >= Lead3Min && b <= Lead3Max) begin
        owed = 2'd2;
        len_class = ClassThree;
        accum = code_t'(b[3:0]);
      end else if (b >= Lead4Min && b <= Lead4Max) begin
        owed = 2'd3;
        len_class = ClassFour;
        accum = code_t'(b[2:0]);
      end else begin
        err = ST_BAD_LEAD;
        err_owed = 2'd0;
      end
    end else if (b[7:6] != ContTag) begin
      err = ST_BAD_CONT;
      err_owed = owed - 2'd1;
      owed = 2'd0;
    end else begin
      accum = {accum[CodeWidth-7:0], b[5:0]};
      owed = owed - 2'd1;
      if (owed == 2'd0) begin
        case (len_class)
          ClassTwo:   minimum = Min2Byte;
          ClassThree: minimum = Min3Byte;
          ClassFour:  minimum = Min4Byte;
          default:    minimum = '0;
        endcase
        if (accum >= minimum && accum <= ScalarMax &&
            !(accum >= SurrogateLow && accum <= SurrogateHigh)) begin
          r.ends = 1'b1;
        end else begin
          err = ST_BAD_SCALAR;
          err_owed = 2'd0;
        end
        len_class = ClassOne;
        accum = '0;
      end
    end
    still_owed = (err == ST_OK) ? (owed != 2'd0) : (err_owed != 2'd0);
    if (last) begin
      r.st = still_owed ? ST_TRUNCATED : err;
      owed = '0;
      accum = '0;
      len_class = ClassOne;
      err = ST_OK;
      err_owed = '0;
    end
    return r;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic last, input logic given,
                           input verdict_t given_v);
    verdict_t v;
    src_valid   <= 1'b1;
    data_byte   <= b;
    end_of_text <= last;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    v = decode_byte(b, last);
    verdict_q.push_back(given ? given_v : v);
    accepted_in++;
    if (!quiet && !rx_holding && !calm && $urandom_range(0, 3) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic append_scalar();
    int    len;
    int    sel;
    code_t v;
    len = $urandom_range(1, 4);
    sel = $urandom_range(0, 9);
    if (sel == 0 && len > 1) begin
      case (len)
        2:       v = code_t'($urandom_range(0, 32'h7F));
        3:       v = code_t'($urandom_range(0, 32'h7FF));
        default: v = code_t'($urandom_range(0, 32'hFFFF));
      endcase
    end else if (sel <= 3) begin
      case (len)
        1: v = $urandom_range(0, 1) ? 21'h00007F : 21'h000000;
        2: v = $urandom_range(0, 1) ? 21'h0007FF : Min2Byte;
        3: begin
          case ($urandom_range(0, 5))
            0:       v = Min3Byte;
            1:       v = 21'h00FFFF;
            2:       v = 21'h00D7FF;
            3:       v = 21'h00E000;
            4:       v = SurrogateLow;
            default: v = SurrogateHigh;
          endcase
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       v = Min4Byte;
            1:       v = ScalarMax;
            default: v = 21'h110000;
          endcase
        end
      endcase
    end else begin
      case (len)
        1:       v = code_t'($urandom_range(0, 32'h7F));
        2:       v = code_t'($urandom_range(32'h80, 32'h7FF));
        3:       v = code_t'($urandom_range(32'h800, 32'hFFFF));
        default: v = code_t'($urandom_range(32'h10000, 32'h10FFFF));
      endcase
    end
    case (len)
      1: text_bytes.push_back({1'b0, v[6:0]});
      2: begin
        text_bytes.push_back({3'b110, v[10:6]});
        text_bytes.push_back({2'b10, v[5:0]});
      end
      3: begin
        text_bytes.push_back({4'b1110, v[15:12]});
        text_bytes.push_back({2'b10, v[11:6]});
        text_bytes.push_back({2'b10, v[5:0]});
      end
      default: begin
        text_bytes.push_back({5'b11110, v[20:18]});
        text_bytes.push_back({2'b10, v[17:12]});
        text_bytes.push_back({2'b10, v[11:6]});
        text_bytes.push_back({2'b10, v[5:0]});
      end
    endcase
  endtask

  task automatic build_text();
    int kind;
    int n;
    int k;
    text_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) text_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 5);
      for (k = 0; k < n; k++) append_scalar();
      if (kind <= 2) begin
        if (text_bytes.size() > 1 && $urandom_range(0, 1)) begin
          n = $urandom_range(1, text_bytes.size() - 1);
          for (k = 0; k < n; k++) void'(text_bytes.pop_back());
        end else begin
          text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
      end
    end
  endtask

  initial begin
    int  stall_left;
    int  calm_left;
    bit  rx_calm;
    stall_left = 0;
    calm_left  = 0;
    rx_calm    = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && accepted_in >= 100) begin
        rx_holding = 1'b1;
        res_stall <= 1'b1;
        repeat (200) @(posedge clk);
        rx_holding = 1'b0;
        long_hold_done = 1'b1;
        res_stall <= 1'b0;
      end else if (quiet) begin
        res_stall <= 1'b0;
      end else if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
        if (calm_left == 0) begin
          rx_calm   = ($urandom_range(0, 3) == 0);
          calm_left = 40;
        end
        calm_left--;
        if (!rx_calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk) begin
    if (out_fire) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected transaction: scalar_ends %0b verdict_ready %0b status %0d",
                 $time, scalar_ends, verdict_ready, status);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (scalar_ends !== want.ends) begin
          $display("%0t: scalar_ends expected %0b actual %0b", $time, want.ends, scalar_ends);
          errors++;
        end
        if (verdict_ready !== want.ready) begin
          $display("%0t: verdict_ready expected %0b actual %0b", $time, want.ready,
                   verdict_ready);
          errors++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          errors++;
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_utf8_stream_validator failed");
    $finish;
  end

  initial begin
    int i;
    int j;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < DirectedRows; i++) begin
      send_item(Directed[i].b, Directed[i].last, Directed[i].given, Directed[i].v);
    end
    src_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    while (random_bytes < 400) begin
      build_text();
      calm = ($urandom_range(0, 4) == 0);
      for (j = 0; j < text_bytes.size(); j++) begin
        send_item(text_bytes[j], j == text_bytes.size() - 1, 1'b0, NoVerdict);
        random_bytes++;
        if (random_bytes >= 330) quiet = 1'b1;
      end
      if (!paused && random_bytes >= 200) begin
        paused = 1'b1;
        src_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
      end
    end
    src_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("tb_utf8_stream_validator passed");
    end else begin
      $display("tb_utf8_stream_validator failed");
    end
    $finish;
  end

endmodule
